[rtl/tfn_pkg.sv]
// Shared constants, types and width helpers for the triangle face normal block.
package tfn_pkg;

  // Three axes per vertex and per normal
  localparam int NUM_AXES = 3;

  // Each normal goes out once per vertex
  localparam int NUM_COPIES = 3;
  localparam int COPY_W = $clog2(NUM_COPIES);

  typedef logic [COPY_W-1:0] copy_cnt_t;

  localparam copy_cnt_t LAST_COPY = copy_cnt_t'(NUM_COPIES - 1);

  // Edge vector component: difference of two coordinates
  function automatic int diff_w(int coord_w);
    return coord_w + 1;
  endfunction

  // Signed product of a pair of edge components
  function automatic int prod_w(int coord_w);
    return 2 * diff_w(coord_w);
  endfunction

  // Cross product component: difference of two products
  function automatic int cross_w(int coord_w);
    return prod_w(coord_w) + 1;
  endfunction

  // Square of a cross component (sign bit of the operand not needed)
  function automatic int sq_w(int coord_w);
    return 2 * cross_w(coord_w) - 2;
  endfunction

  // Sum of three squares
  function automatic int sum_w(int coord_w);
    return sq_w(coord_w) + 2;
  endfunction

  // Remainder and partial product width in the square-root-free search
  function automatic int work_w(int coord_w, int frac_bits);
    return sum_w(coord_w) + 2 * frac_bits + 2;
  endfunction

  // Normal component: sign plus magnitude up to 2^frac_bits
  function automatic int normal_w(int frac_bits);
    return frac_bits + 2;
  endfunction

endpackage

[rtl/tfn_cross.sv]
// Edge vectors and cross product, three register stages.
module tfn_cross #(
  parameter int COORD_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [tfn_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] vert_a_i,
  input  logic [tfn_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] vert_b_i,
  input  logic [tfn_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] vert_c_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [tfn_pkg::NUM_AXES-1:0][tfn_pkg::cross_w(COORD_WIDTH)-1:0] cross_o
);

  localparam int NA      = tfn_pkg::NUM_AXES;
  localparam int DIFF_W  = tfn_pkg::diff_w(COORD_WIDTH);
  localparam int PROD_W  = tfn_pkg::prod_w(COORD_WIDTH);
  localparam int CROSS_W = tfn_pkg::cross_w(COORD_WIDTH);

  logic dif_valid_q, prd_valid_q, crs_valid_q;
  logic dif_ready, prd_ready, crs_ready;
  logic dif_load, prd_load, crs_load;

  logic [NA-1:0][DIFF_W-1:0]  u_d, v_d, u_q, v_q;
  logic [NA-1:0][PROD_W-1:0]  pa_d, pb_d, pa_q, pb_q;
  logic [NA-1:0][CROSS_W-1:0] r_d, r_q;

  // Stage ready chain
  assign crs_ready  = !crs_valid_q || out_ready_i;
  assign prd_ready  = !prd_valid_q || crs_ready;
  assign dif_ready  = !dif_valid_q || prd_ready;
  assign in_ready_o = dif_ready;

  assign dif_load = in_valid_i && dif_ready;
  assign crs_load = prd_valid_q && crs_ready;
  assign prd_load = dif_valid_q && prd_ready;

  // Per-axis arithmetic; j and k are the two other axes
  for (genvar i = 0; i < NA; i++) begin : g_axis
    localparam int J = (i + 1) % NA;
    localparam int K = (i + 2) % NA;

    assign u_d[i] = DIFF_W'($signed(vert_c_i[i])) - DIFF_W'($signed(vert_a_i[i]));
    assign v_d[i] = DIFF_W'($signed(vert_c_i[i])) - DIFF_W'($signed(vert_b_i[i]));

    assign pa_d[i] = PROD_W'($signed(u_q[J])) * PROD_W'($signed(v_q[K]));
    assign pb_d[i] = PROD_W'($signed(u_q[K])) * PROD_W'($signed(v_q[J]));

    assign r_d[i] = CROSS_W'($signed(pa_q[i])) - CROSS_W'($signed(pb_q[i]));
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dif_valid_q <= 1'b0;
      prd_valid_q <= 1'b0;
      crs_valid_q <= 1'b0;
    end else begin
      if (dif_ready) dif_valid_q <= in_valid_i;
      if (prd_ready) prd_valid_q <= dif_valid_q;
      if (crs_ready) crs_valid_q <= prd_valid_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (dif_load) begin
      u_q <= u_d;
      v_q <= v_d;
    end
    if (prd_load) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
    if (crs_load) begin
      r_q <= r_d;
    end
  end

  assign out_valid_o = crs_valid_q;
  assign cross_o     = r_q;

endmodule

[rtl/tfn_sumsq.sv]
// Squares of the cross components and their sum, two register stages.
module tfn_sumsq #(
  parameter int COORD_WIDTH      = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [tfn_pkg::NUM_AXES-1:0][tfn_pkg::cross_w(COORD_WIDTH)-1:0] cross_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [tfn_pkg::sum_w(COORD_WIDTH)-1:0] sum_o,
  output logic degen_o,
  output logic [tfn_pkg::NUM_AXES-1:0] neg_o,
  output logic [tfn_pkg::NUM_AXES-1:0]
               [tfn_pkg::work_w(COORD_WIDTH, NORMAL_FRAC_BITS)-1:0] rem_o
);

  localparam int NA      = tfn_pkg::NUM_AXES;
  localparam int CROSS_W = tfn_pkg::cross_w(COORD_WIDTH);
  localparam int SQF_W   = 2 * CROSS_W;
  localparam int SQ_W    = tfn_pkg::sq_w(COORD_WIDTH);
  localparam int SUM_W   = tfn_pkg::sum_w(COORD_WIDTH);
  localparam int WORK_W  = tfn_pkg::work_w(COORD_WIDTH, NORMAL_FRAC_BITS);

  logic sq_valid_q, sm_valid_q;
  logic sq_ready, sm_ready;
  logic sq_load, sm_load;

  logic [NA-1:0][SQF_W-1:0]  sq_full;
  logic [NA-1:0][SQ_W-1:0]   sq_d, sq_q;
  logic [NA-1:0]             neg_d, sq_neg_q, sm_neg_q;
  logic                      degen_d, sq_degen_q, sm_degen_q;
  logic [SUM_W-1:0]          sum_d, sum_q;
  logic [NA-1:0][WORK_W-1:0] rem_d, rem_q;

  assign sm_ready   = !sm_valid_q || out_ready_i;
  assign sq_ready   = !sq_valid_q || sm_ready;
  assign in_ready_o = sq_ready;

  assign sq_load = in_valid_i && sq_ready;
  assign sm_load = sq_valid_q && sm_ready;

  // Squaring the signed value gives the square of the magnitude
  for (genvar i = 0; i < NA; i++) begin : g_sq
    assign sq_full[i] = SQF_W'($signed(cross_i[i])) * SQF_W'($signed(cross_i[i]));
    assign sq_d[i]    = sq_full[i][SQ_W-1:0];
    assign neg_d[i]   = cross_i[i][CROSS_W-1];
    // Dividend of the search: r^2 scaled by 2^(2F)
    assign rem_d[i]   = WORK_W'(sq_q[i]) << (2 * NORMAL_FRAC_BITS);
  end

  // Zero cross product: normal is forced to zero downstream
  assign degen_d = (cross_i == '0);

  assign sum_d = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
      sm_valid_q <= 1'b0;
    end else begin
      if (sq_ready) sq_valid_q <= in_valid_i;
      if (sm_ready) sm_valid_q <= sq_valid_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (sq_load) begin
      sq_q       <= sq_d;
      sq_neg_q   <= neg_d;
      sq_degen_q <= degen_d;
    end
    if (sm_load) begin
      sum_q      <= sum_d;
      rem_q      <= rem_d;
      sm_neg_q   <= sq_neg_q;
      sm_degen_q <= sq_degen_q;
    end
  end

  assign out_valid_o = sm_valid_q;
  assign sum_o       = sum_q;
  assign degen_o     = sm_degen_q;
  assign neg_o       = sm_neg_q;
  assign rem_o       = rem_q;

endmodule

[rtl/tfn_div_step.sv]
// One bit of the normalising search for all three axes, one register stage.
module tfn_div_step #(
  parameter int COORD_WIDTH      = 16,
  parameter int NORMAL_FRAC_BITS = 14,
  parameter int STEP_BIT         = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [tfn_pkg::sum_w(COORD_WIDTH)-1:0] sum_i,
  input  logic degen_i,
  input  logic [tfn_pkg::NUM_AXES-1:0] neg_i,
  input  logic [tfn_pkg::NUM_AXES-1:0][NORMAL_FRAC_BITS:0] quo_i,
  input  logic [tfn_pkg::NUM_AXES-1:0]
               [tfn_pkg::work_w(COORD_WIDTH, NORMAL_FRAC_BITS)-1:0] rem_i,
  input  logic [tfn_pkg::NUM_AXES-1:0]
               [tfn_pkg::work_w(COORD_WIDTH, NORMAL_FRAC_BITS)-1:0] qs_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [tfn_pkg::sum_w(COORD_WIDTH)-1:0] sum_o,
  output logic degen_o,
  output logic [tfn_pkg::NUM_AXES-1:0] neg_o,
  output logic [tfn_pkg::NUM_AXES-1:0][NORMAL_FRAC_BITS:0] quo_o,
  output logic [tfn_pkg::NUM_AXES-1:0]
               [tfn_pkg::work_w(COORD_WIDTH, NORMAL_FRAC_BITS)-1:0] rem_o,
  output logic [tfn_pkg::NUM_AXES-1:0]
               [tfn_pkg::work_w(COORD_WIDTH, NORMAL_FRAC_BITS)-1:0] qs_o
);

  localparam int NA     = tfn_pkg::NUM_AXES;
  localparam int SUM_W  = tfn_pkg::sum_w(COORD_WIDTH);
  localparam int WORK_W = tfn_pkg::work_w(COORD_WIDTH, NORMAL_FRAC_BITS);
  localparam int Q_W    = NORMAL_FRAC_BITS + 1;

  logic valid_q, load;

  logic [WORK_W-1:0]         sum_sq_sh, sum_sh;
  logic [NA-1:0][WORK_W-1:0] qs_sh;
  logic [NA-1:0][WORK_W:0]   trial;
  logic [NA-1:0]             take;
  logic [NA-1:0][Q_W-1:0]    quo_d, quo_q;
  logic [NA-1:0][WORK_W-1:0] rem_d, rem_q, qs_d, qs_q;
  logic [SUM_W-1:0]          sum_q;
  logic                      degen_q;
  logic [NA-1:0]             neg_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // S * 2^(2b) and S * 2^b for the current bit b
  assign sum_sq_sh = WORK_W'(sum_i) << (2 * STEP_BIT);
  assign sum_sh    = WORK_W'(sum_i) << STEP_BIT;

  // (q + 2^b)^2 S = q^2 S + q S 2^(b+1) + S 2^(2b); the remainder holds
  // r^2 2^(2F) - q^2 S, so the bit is kept when the trial stays non-negative
  for (genvar i = 0; i < NA; i++) begin : g_lane
    assign qs_sh[i] = qs_i[i] << (STEP_BIT + 1);
    assign trial[i] = {1'b0, rem_i[i]} - {1'b0, qs_sh[i]} - {1'b0, sum_sq_sh};
    // A magnitude already at 2^F takes no further bits
    assign take[i]  = !degen_i && !quo_i[i][Q_W-1] && !trial[i][WORK_W];

    assign quo_d[i] = take[i] ? (quo_i[i] | (Q_W'(1) << STEP_BIT)) : quo_i[i];
    assign rem_d[i] = take[i] ? trial[i][WORK_W-1:0] : rem_i[i];
    assign qs_d[i]  = take[i] ? (qs_i[i] + sum_sh) : qs_i[i];
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      sum_q   <= sum_i;
      degen_q <= degen_i;
      neg_q   <= neg_i;
      quo_q   <= quo_d;
      rem_q   <= rem_d;
      qs_q    <= qs_d;
    end
  end

  assign out_valid_o = valid_q;
  assign sum_o       = sum_q;
  assign degen_o     = degen_q;
  assign neg_o       = neg_q;
  assign quo_o       = quo_q;
  assign rem_o       = rem_q;
  assign qs_o        = qs_q;

endmodule

[rtl/tfn_out.sv]
// Output register: signs the normal and sends it once per vertex.
module tfn_out #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic degen_i,
  input  logic [tfn_pkg::NUM_AXES-1:0] neg_i,
  input  logic [tfn_pkg::NUM_AXES-1:0][NORMAL_FRAC_BITS:0] quo_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [tfn_pkg::NUM_AXES-1:0][tfn_pkg::normal_w(NORMAL_FRAC_BITS)-1:0] normal_o,
  output logic last_o
);

  localparam int NA   = tfn_pkg::NUM_AXES;
  localparam int NW   = tfn_pkg::normal_w(NORMAL_FRAC_BITS);

  logic              valid_q, load, xfer, done;
  tfn_pkg::copy_cnt_t copy_q;
  logic [NA-1:0][NW-1:0] normal_d, normal_q;

  assign xfer       = valid_q && out_ready_i;
  assign done       = xfer && (copy_q == tfn_pkg::LAST_COPY);
  assign in_ready_o = !valid_q || done;
  assign load       = in_valid_i && in_ready_o;

  // Apply the sign; a degenerate triangle gives zeros
  for (genvar i = 0; i < NA; i++) begin : g_sign
    always_comb begin
      if (degen_i) begin
        normal_d[i] = '0;
      end else if (neg_i[i]) begin
        normal_d[i] = -NW'(quo_i[i]);
      end else begin
        normal_d[i] = NW'(quo_i[i]);
      end
    end
  end

  // Valid and copy counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      copy_q  <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      copy_q  <= '0;
    end else if (done) begin
      valid_q <= 1'b0;
    end else if (xfer) begin
      copy_q  <= tfn_pkg::copy_cnt_t'(copy_q + 1'b1);
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      normal_q <= normal_d;
    end
  end

  assign out_valid_o = valid_q;
  assign normal_o    = normal_q;
  assign last_o      = (copy_q == tfn_pkg::LAST_COPY);

endmodule

[rtl/triangle_face_normal.sv]
// Top level of the triangle face normal pipeline.
//
// Takes one triangle per transaction on the s_axis channel: nine signed
// coordinates a, b, c (x, y, z each), packed from the low bits of tdata.
// Forms the cross product of (c - a) and (c - b) exactly and scales it to
// unit length, each component signed with NORMAL_FRAC_BITS fraction bits,
// truncated toward zero. A zero cross product gives a zero normal.
// The normal leaves on m_axis three times, once per vertex; tlast marks
// the third copy.
// From input transaction to the first copy the data passes three
// cross-product stages, two stages for the squares and their sum, one
// stage per result bit of the normalising search, and the output
// register. The output register sends three copies per triangle and
// takes the next triangle only as the last copy goes; the pipeline
// keeps taking triangles until every stage is full.
// Reset clears all valid bits; the pipeline is then empty and ready.
// When the receiver stalls, the output holds its copy and stages fill up
// behind it; nothing is dropped or repeated.
module triangle_face_normal #(
  parameter int COORD_WIDTH      = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // ax, ay, az, bx, by, bz, cx, cy, cz from the lowest bit up
  input  logic [((9 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // normal_x, normal_y, normal_z from the lowest bit up
  output logic [((3 * (NORMAL_FRAC_BITS + 2) + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // last_copy
  output logic m_axis_tlast
);

  localparam int NA        = tfn_pkg::NUM_AXES;
  localparam int CROSS_W   = tfn_pkg::cross_w(COORD_WIDTH);
  localparam int SUM_W     = tfn_pkg::sum_w(COORD_WIDTH);
  localparam int WORK_W    = tfn_pkg::work_w(COORD_WIDTH, NORMAL_FRAC_BITS);
  localparam int NW        = tfn_pkg::normal_w(NORMAL_FRAC_BITS);
  localparam int Q_W       = NORMAL_FRAC_BITS + 1;
  localparam int NUM_STEPS = NORMAL_FRAC_BITS + 1;
  localparam int OUT_TD_W  = ((3 * NW + 7) / 8) * 8;

  logic [NA-1:0][COORD_WIDTH-1:0] vert_a, vert_b, vert_c;

  logic                    crs_valid, crs_ready;
  logic [NA-1:0][CROSS_W-1:0] crs_val;

  // Search chain: index 0 is the sum stage output, the last feeds the output
  logic [NUM_STEPS:0]                    stp_valid, stp_ready, stp_degen;
  logic [NUM_STEPS:0][SUM_W-1:0]         stp_sum;
  logic [NUM_STEPS:0][NA-1:0]            stp_neg;
  logic [NUM_STEPS:0][NA-1:0][Q_W-1:0]   stp_quo;
  logic [NUM_STEPS:0][NA-1:0][WORK_W-1:0] stp_rem, stp_qs;

  logic [NA-1:0][NW-1:0] normal;

  // Unpack the vertices
  for (genvar i = 0; i < NA; i++) begin : g_unpack
    assign vert_a[i] = s_axis_tdata[i * COORD_WIDTH +: COORD_WIDTH];
    assign vert_b[i] = s_axis_tdata[(NA + i) * COORD_WIDTH +: COORD_WIDTH];
    assign vert_c[i] = s_axis_tdata[(2 * NA + i) * COORD_WIDTH +: COORD_WIDTH];
  end

  tfn_cross #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_cross (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .vert_a_i    (vert_a),
    .vert_b_i    (vert_b),
    .vert_c_i    (vert_c),
    .out_valid_o (crs_valid),
    .out_ready_i (crs_ready),
    .cross_o     (crs_val)
  );

  tfn_sumsq #(
    .COORD_WIDTH      (COORD_WIDTH),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_sumsq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (crs_valid),
    .in_ready_o  (crs_ready),
    .cross_i     (crs_val),
    .out_valid_o (stp_valid[0]),
    .out_ready_i (stp_ready[0]),
    .sum_o       (stp_sum[0]),
    .degen_o     (stp_degen[0]),
    .neg_o       (stp_neg[0]),
    .rem_o       (stp_rem[0])
  );

  // Search starts from a zero quotient
  assign stp_quo[0] = '0;
  assign stp_qs[0]  = '0;

  // One stage per result bit, most significant first
  for (genvar s = 0; s < NUM_STEPS; s++) begin : g_step
    tfn_div_step #(
      .COORD_WIDTH      (COORD_WIDTH),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
      .STEP_BIT         (NORMAL_FRAC_BITS - s)
    ) u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stp_valid[s]),
      .in_ready_o  (stp_ready[s]),
      .sum_i       (stp_sum[s]),
      .degen_i     (stp_degen[s]),
      .neg_i       (stp_neg[s]),
      .quo_i       (stp_quo[s]),
      .rem_i       (stp_rem[s]),
      .qs_i        (stp_qs[s]),
      .out_valid_o (stp_valid[s+1]),
      .out_ready_i (stp_ready[s+1]),
      .sum_o       (stp_sum[s+1]),
      .degen_o     (stp_degen[s+1]),
      .neg_o       (stp_neg[s+1]),
      .quo_o       (stp_quo[s+1]),
      .rem_o       (stp_rem[s+1]),
      .qs_o        (stp_qs[s+1])
    );
  end

  tfn_out #(
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stp_valid[NUM_STEPS]),
    .in_ready_o  (stp_ready[NUM_STEPS]),
    .degen_i     (stp_degen[NUM_STEPS]),
    .neg_i       (stp_neg[NUM_STEPS]),
    .quo_i       (stp_quo[NUM_STEPS]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .normal_o    (normal),
    .last_o      (m_axis_tlast)
  );

  // Pack the normal, zero fill to whole bytes
  assign m_axis_tdata = OUT_TD_W'(normal);

endmodule

[tb/sv/triangle_face_normal_tb.sv]
// Self-checking testbench for the triangle face normal block.
`timescale 1ns / 100ps

module triangle_face_normal_tb;

  localparam int COORD_W    = 16;
  localparam int FRAC       = 14;
  localparam int IN_W       = ((9 * COORD_W + 7) / 8) * 8;
  localparam int OUT_W      = ((3 * (FRAC + 2) + 7) / 8) * 8;
  localparam int LATENCY    = FRAC + 7;
  localparam int CLK_HALF   = 6;
  localparam int QUIET_MAX  = 1000;
  localparam int RAND_ITEMS = 44;
  localparam int NUM_DIR    = 18;
  localparam int UNIT       = 1 << FRAC;

  // Triangle as packed on s_axis_tdata: ax in the lowest bits
  typedef struct packed {
    logic signed [COORD_W-1:0] cz, cy, cx, bz, by, bx, az, ay, ax;
  } face_t;

  // Normal as packed on m_axis_tdata: nx in the lowest bits
  typedef struct packed {
    logic signed [15:0] nz, ny, nx;
  } normal_t;

  typedef struct packed {
    normal_t n;
    logic    last;
  } copy_t;

  // Directed row: expected normal typed in only where known is set
  typedef struct packed {
    face_t   f;
    logic    known;
    normal_t n;
  } stim_row_t;

  typedef enum int {SHAPE_WIDE, SHAPE_NEAR, SHAPE_EXTREME, SHAPE_REPEAT,
                    SHAPE_COLLINEAR} shape_e;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;

  copy_t pending_copies [$];
  int    mismatches  = 0;
  int    tx_idle_pct = 0;
  int    rx_idle_pct = 0;
  int    quiet_cycles = 0;

  stim_row_t dir_rows [0:NUM_DIR-1];

  triangle_face_normal #(
    .COORD_WIDTH      (COORD_W),
    .NORMAL_FRAC_BITS (FRAC)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Exact unit normal: cross product at full width, then a bitwise search
  // for the largest q with q^2 * |r|^2 <= r_i^2 * 2^(2*FRAC)
  function automatic normal_t unit_face_normal(face_t f);
    longint       ux, uy, uz, vx, vy, vz;
    longint       cr [3];
    logic [127:0] mag [3];
    logic [127:0] sum_sq, rhs, t_sq;
    int unsigned  q, t;
    int           comp [3];
    normal_t      n;
    ux = longint'(f.cx) - longint'(f.ax);
    uy = longint'(f.cy) - longint'(f.ay);
    uz = longint'(f.cz) - longint'(f.az);
    vx = longint'(f.cx) - longint'(f.bx);
    vy = longint'(f.cy) - longint'(f.by);
    vz = longint'(f.cz) - longint'(f.bz);
    cr[0] = uy * vz - uz * vy;
    cr[1] = uz * vx - ux * vz;
    cr[2] = ux * vy - uy * vx;
    sum_sq = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (cr[i] < 0) ? 128'(-cr[i]) : 128'(cr[i]);
      sum_sq = sum_sq + mag[i] * mag[i];
      comp[i] = 0;
    end
    // degenerate triangle leaves the normal at zero
    if (sum_sq != 0) begin
      for (int i = 0; i < 3; i++) begin
        rhs = (mag[i] * mag[i]) << (2 * FRAC);
        q = 0;
        for (int b = FRAC; b >= 0; b--) begin
          t = q | (32'd1 << b);
          if (t <= UNIT) begin
            t_sq = 128'(t) * 128'(t);
            if (t_sq * sum_sq <= rhs) q = t;
          end
        end
        comp[i] = (cr[i] < 0) ? -int'(q) : int'(q);
      end
    end
    n.nx = 16'(comp[0]);
    n.ny = 16'(comp[1]);
    n.nz = 16'(comp[2]);
    return n;
  endfunction

  function automatic stim_row_t drow(int ax, int ay, int az, int bx, int by, int bz,
                                     int cx, int cy, int cz, logic known,
                                     int nx, int ny, int nz);
    stim_row_t r;
    r.f.ax = 16'(ax); r.f.ay = 16'(ay); r.f.az = 16'(az);
    r.f.bx = 16'(bx); r.f.by = 16'(by); r.f.bz = 16'(bz);
    r.f.cx = 16'(cx); r.f.cy = 16'(cy); r.f.cz = 16'(cz);
    r.known = known;
    r.n.nx = 16'(nx); r.n.ny = 16'(ny); r.n.nz = 16'(nz);
    return r;
  endfunction

  function automatic logic signed [15:0] extreme_coord();
    int pick;
    pick = $urandom_range(0, 4);
    case (pick)
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return -16'sd1;
      3:       return 16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  // Random triangle; mostly proper faces, some degenerate ones
  function automatic face_t rand_face();
    face_t  f;
    shape_e shape;
    int     sel, ox, oy, oz, dx, dy, dz, k1, k2;
    sel = $urandom_range(0, 9);
    shape = (sel < 4) ? SHAPE_WIDE :
            (sel < 6) ? SHAPE_NEAR :
            (sel < 8) ? SHAPE_EXTREME :
            (sel < 9) ? SHAPE_REPEAT : SHAPE_COLLINEAR;
    f = face_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    case (shape)
      SHAPE_NEAR: begin
        // small triangle far from the origin: small cross products
        ox = $signed($urandom_range(0, 60000)) - 30000;
        oy = $signed($urandom_range(0, 60000)) - 30000;
        oz = $signed($urandom_range(0, 60000)) - 30000;
        f.ax = 16'(ox); f.ay = 16'(oy); f.az = 16'(oz);
        f.bx = 16'(ox + $signed($urandom_range(0, 1000)) - 500);
        f.by = 16'(oy + $signed($urandom_range(0, 1000)) - 500);
        f.bz = 16'(oz + $signed($urandom_range(0, 1000)) - 500);
        f.cx = 16'(ox + $signed($urandom_range(0, 1000)) - 500);
        f.cy = 16'(oy + $signed($urandom_range(0, 1000)) - 500);
        f.cz = 16'(oz + $signed($urandom_range(0, 1000)) - 500);
      end
      SHAPE_EXTREME: begin
        f.ax = extreme_coord(); f.ay = extreme_coord(); f.az = extreme_coord();
        f.bx = extreme_coord(); f.by = extreme_coord(); f.bz = extreme_coord();
        f.cx = extreme_coord(); f.cy = extreme_coord(); f.cz = extreme_coord();
      end
      SHAPE_REPEAT: begin
        // two vertices coincide
        if ($urandom_range(0, 1) == 0) begin
          f.bx = f.ax; f.by = f.ay; f.bz = f.az;
        end else begin
          f.cx = f.bx; f.cy = f.by; f.cz = f.bz;
        end
      end
      SHAPE_COLLINEAR: begin
        ox = $signed($urandom_range(0, 8192)) - 4096;
        oy = $signed($urandom_range(0, 8192)) - 4096;
        oz = $signed($urandom_range(0, 8192)) - 4096;
        dx = $signed($urandom_range(0, 2048)) - 1024;
        dy = $signed($urandom_range(0, 2048)) - 1024;
        dz = $signed($urandom_range(0, 2048)) - 1024;
        k1 = $signed($urandom_range(0, 6)) - 3;
        k2 = $signed($urandom_range(0, 6)) - 3;
        f.ax = 16'(ox); f.ay = 16'(oy); f.az = 16'(oz);
        f.bx = 16'(ox + k1 * dx); f.by = 16'(oy + k1 * dy); f.bz = 16'(oz + k1 * dz);
        f.cx = 16'(ox + k2 * dx); f.cy = 16'(oy + k2 * dy); f.cz = 16'(oz + k2 * dz);
      end
      default: ;
    endcase
    return f;
  endfunction

  // Present one triangle, wait for its transaction, queue its three copies
  task automatic send_face(input face_t f, input logic known, input normal_t typed_n);
    normal_t n;
    copy_t   c;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= f;
    do @(posedge clk_i); while (!s_axis_tready);
    n = known ? typed_n : unit_face_normal(f);
    for (int k = 0; k < tfn_pkg::NUM_COPIES; k++) begin
      c.n    = n;
      c.last = (k == tfn_pkg::NUM_COPIES - 1);
      pending_copies = {pending_copies, c};
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Receiver back-pressure
  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

  // Output checker: each transaction against the oldest queued copy
  always @(posedge clk_i) begin
    copy_t   want;
    normal_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_copies.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected normal, expected none, actual x=%0d y=%0d z=%0d last=%0b",
                 $time, got.nx, got.ny, got.nz, m_axis_tlast);
      end else begin
        want = pending_copies.pop_front();
        check_field("normal_x", want.n.nx, got.nx);
        check_field("normal_y", want.n.ny, got.ny);
        check_field("normal_z", want.n.nz, got.nz);
        check_field("last_copy", int'(want.last), int'(m_axis_tlast));
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int tx_pct_by_phase [3];
    int rx_pct_by_phase [3];
    tx_pct_by_phase = '{13, 71, 0};
    rx_pct_by_phase = '{71, 13, 0};

    // Directed triangles: axis-aligned faces and degenerate ones have
    // normals known by inspection
    dir_rows = '{
      drow(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0),
      drow(0, 0, 0, 256, 0, 0, 0, 256, 0, 1'b1, 0, 0, UNIT),
      drow(0, 0, 0, 0, 256, 0, 256, 0, 0, 1'b1, 0, 0, -UNIT),
      drow(0, 0, 0, 0, 0, 32767, 0, 32767, 0, 1'b1, -UNIT, 0, 0),
      drow(-32768, 0, -32768, 32767, 0, -32768, -32768, 0, 32767, 1'b1, 0, -UNIT, 0),
      drow(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
           1'b1, 0, 0, 0),
      drow(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
           1'b1, 0, 0, 0),
      drow(-32768, -32768, -32768, 0, 0, 0, 32767, 32767, 32767, 1'b1, 0, 0, 0),
      drow(-32768, -32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767,
           1'b0, 0, 0, 0),
      drow(32767, 32767, -32768, -32768, 32767, 32767, 32767, -32768, 32767,
           1'b0, 0, 0, 0),
      drow(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767, -32768,
           1'b0, 0, 0, 0),
      drow(-32768, 32767, 0, 32767, -32768, 0, 0, 0, 32767, 1'b0, 0, 0, 0),
      drow(32767, 0, 0, 0, 32767, 0, 0, 0, 32767, 1'b0, 0, 0, 0),
      drow(0, 0, 0, 1, 0, 0, 0, 1, 1, 1'b0, 0, 0, 0),
      drow(0, 0, 0, 1, 2, 3, 3, 1, 2, 1'b0, 0, 0, 0),
      drow(-1, -1, -1, 0, 0, 0, 1, -1, 0, 1'b0, 0, 0, 0),
      drow(100, 200, 300, -400, 500, -600, 700, -800, 900, 1'b0, 0, 0, 0),
      drow(0, 0, 0, 3, 4, 0, 0, 0, 5, 1'b0, 0, 0, 0)
    };

    // Reset, once
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = tx_pct_by_phase[p];
      rx_idle_pct = rx_pct_by_phase[p];
      if (p == 0)
        for (int i = 0; i < NUM_DIR; i++)
          send_face(dir_rows[i].f, dir_rows[i].known, dir_rows[i].n);
      for (int i = 0; i < RAND_ITEMS; i++)
        send_face(rand_face(), 1'b0, '0);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // Drain, then allow for anything stray
    while (pending_copies.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[triangle_face_normal.f]
rtl/tfn_pkg.sv
rtl/tfn_cross.sv
rtl/tfn_sumsq.sv
rtl/tfn_div_step.sv
rtl/tfn_out.sv
rtl/triangle_face_normal.sv
tb/sv/triangle_face_normal_tb.sv
